// ----- sv/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    // Queue size and derived widths
    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int VALUE_W   = 32;
    localparam int PRI_W     = 16;
    localparam int ENTRIES_W = 5;
    localparam int ENTRY_W   = VALUE_W + PRI_W;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // One stored pair
    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_PLACE = 5'b00100,
        S_FETCH = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue of up to 16 (value, priority) pairs.
// Input beats arrive on s_axis: tuser carries the command (insert, dequeue,
// peek), tdata the value and priority. Every input beat gives exactly one
// result beat on m_axis: tdata carries the served value, its priority and
// the entry count after the command, tuser carries the status.
// Pairs sit in one simple dual-port RAM in ascending priority order, so
// the highest priority is always at address count-1; ties go to the most
// recent insert.
// A peek or dequeue reads the top entry into the read register and forms
// its result in the fetch state; s_axis_tready is high only in idle.
// An insert walks down from the top, one RAM entry per cycle, moving each
// higher-priority entry up one slot; the pair lands above the first entry
// that stays, or at the bottom in a separate place step. An insert into an
// empty queue, a refused insert, an empty peek/dequeue and code three
// finish in the accept cycle itself.
// Reset clears the count and the handshake state; RAM contents are left
// as they are and are never read below the count.
// When m_axis stalls, the result waits in the output register and the
// block still accepts one more beat; its result is parked until the
// output register frees, and s_axis_tready stays low meanwhile.
`default_nettype none

module sorted_priority_queue
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] item_value, [47:32] item_priority
    input  wire [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  wire [spq_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // [31:0] out_value, [47:32] out_priority, [52:48] entries, rest zero
    output logic [spq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [spq_pkg::STATUS_W-1:0] m_axis_tuser
);
    import spq_pkg::*;

    // Entry RAM
    entry_t mem [DEPTH];
    entry_t rd_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    entry_t             new_reg;
    logic [CMD_W-1:0]   cmd_reg;

    // Parked result and output register
    logic [M_TDATA_W-1:0] pend_data_reg;
    logic [STATUS_W-1:0]  pend_user_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]  out_user_reg;

    // Result produced this cycle
    logic                 res_valid;
    entry_t               res_entry;
    logic [STATUS_W-1:0]  res_status;
    logic [M_TDATA_W-1:0] res_data;

    logic   in_acc;
    logic   out_free;
    logic   is_full;
    logic   is_empty;
    entry_t in_entry;
    logic [ADDR_W-1:0] top_addr;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_full       = (fill_reg == CNT_W'(DEPTH));
    assign is_empty      = (fill_reg == '0);
    assign top_addr      = ADDR_W'(fill_reg - CNT_W'(1));
    assign in_entry.value = s_axis_tdata[VALUE_W-1:0];
    assign in_entry.pri   = s_axis_tdata[VALUE_W +: PRI_W];

    // Sequencer: accept, walk, place, fetch and hold
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg + ADDR_W'(1);
        mem_wdata  = new_reg;
        mem_re     = 1'b0;
        mem_raddr  = top_addr;
        res_valid  = 1'b0;
        res_entry  = '0;
        res_status = STAT_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_axis_tuser)
                        CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_valid  = 1'b1;
                                res_status = STAT_FULL;
                            end
                            else if (is_empty)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = in_entry;
                                fill_next = fill_reg + CNT_W'(1);
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                idx_next   = top_addr;
                                state_next = S_WALK;
                            end
                        end
                        CMD_DEQUEUE, CMD_PEEK:
                        begin
                            if (is_empty)
                            begin
                                res_valid  = 1'b1;
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                mem_we = 1'b1;
                if (rd_reg.pri > new_reg.pri)
                begin
                    // move the higher entry up one slot; keep walking, or place at the bottom
                    mem_wdata = rd_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg - ADDR_W'(1);
                        idx_next  = idx_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    fill_next = fill_reg + CNT_W'(1);
                    res_valid = 1'b1;
                end
            end
            S_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                fill_next = fill_reg + CNT_W'(1);
                res_valid = 1'b1;
            end
            S_FETCH:
            begin
                res_valid = 1'b1;
                res_entry = rd_reg;
                if (cmd_reg == CMD_DEQUEUE)
                begin
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // route a finished result to the output or park it
        if (res_valid)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    assign res_data = {{(M_TDATA_W - ENTRIES_W - ENTRY_W){1'b0}},
                       ENTRIES_W'(fill_next), res_entry.pri, res_entry.value};

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if ((res_valid && out_free) || (state_reg == S_HOLD && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture command, park and drive results
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (in_acc)
        begin
            new_reg <= in_entry;
            cmd_reg <= s_axis_tuser;
        end
        if (res_valid && !out_free)
        begin
            pend_data_reg <= res_data;
            pend_user_reg <= res_status;
        end
        if (res_valid && out_free)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_status;
        end
        else if (state_reg == S_HOLD && out_free)
        begin
            out_data_reg <= pend_data_reg;
            out_user_reg <= pend_user_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ----- sv/spq_checker.sv -----
`default_nettype none

module spq_checker
(
    input wire                           clk,
    input wire                           rst_n,
    input wire                           s_axis_tvalid,
    input wire                           s_axis_tready,
    input wire [spq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input wire [spq_pkg::CMD_W-1:0]      s_axis_tuser,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [spq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire [spq_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import spq_pkg::*;

    logic [ENTRIES_W-1:0] out_entries;
    logic [ENTRY_W-1:0]   out_pair;

    assign out_entries = m_axis_tdata[ENTRY_W +: ENTRIES_W];
    assign out_pair    = m_axis_tdata[ENTRY_W-1:0];

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Count never passes the queue size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_entries <= ENTRIES_W'(DEPTH))
        else $error("entry count beyond queue size");

    // Refused insert only on a full queue, with no pair
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_FULL |->
            out_entries == ENTRIES_W'(DEPTH) && out_pair == '0)
        else $error("full status with wrong count or pair");

    // Empty status only on an empty queue, with no pair
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_EMPTY |->
            out_entries == '0 && out_pair == '0)
        else $error("empty status with wrong count or pair");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

// ----- test/sorted_priority_queue_checker.sv -----
module sorted_priority_queue_checker
    import spq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // [31:0] item_value, [47:32] item_priority
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]     s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] out_value, [47:32] out_priority, [52:48] entries, rest zero
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    input  logic [STATUS_W-1:0]  m_axis_tuser,
    output int                   fail_count,
    output int                   pending,
    output int                   checked,
    output int                   refused,
    output int                   empty_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_W       = M_TDATA_W - VALUE_W - PRI_W - ENTRIES_W;
    localparam int MAX_REPORTS = 10;

    // One result beat, split into its fields
    typedef struct packed {
        logic [PAD_W-1:0]     pad;
        logic [ENTRIES_W-1:0] entries;
        logic [PRI_W-1:0]     pri;
        logic [VALUE_W-1:0]   value;
        logic [STATUS_W-1:0]  status;
    } reply_t;

    // Shadow of the queue, ascending priority, top of queue at held_count - 1
    logic [VALUE_W-1:0] held_value [DEPTH];
    logic [PRI_W-1:0]   held_pri [DEPTH];
    int                 held_count;

    reply_t             queued_replies [$];
    reply_t             want;
    reply_t             got;
    int                 mismatches;
    int                 n_checked;
    int                 n_refused;
    int                 n_empty;

    // Apply one command to the shadow queue and return the reply it earns
    function automatic reply_t serve_command(logic [CMD_W-1:0] cmd,
                                             logic [VALUE_W-1:0] value,
                                             logic [PRI_W-1:0] pri);
        reply_t r;
        int     pos;
        r        = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = STAT_FULL;
                    n_refused++;
                end
                else
                begin
                    // new pair sits above every pair of lower or equal priority
                    pos = 0;
                    while (pos < held_count && held_pri[pos] <= pri)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_value[i] = held_value[i-1];
                        held_pri[i]   = held_pri[i-1];
                    end
                    held_value[pos] = value;
                    held_pri[pos]   = pri;
                    held_count++;
                end
            end
            CMD_DEQUEUE, CMD_PEEK:
            begin
                if (held_count == 0)
                begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.value = held_value[held_count-1];
                    r.pri   = held_pri[held_count-1];
                    if (cmd == CMD_DEQUEUE)
                        held_count--;
                end
            end
            default:
            begin
                // unused code: leave the queue alone
            end
        endcase
        r.entries = ENTRIES_W'(held_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            queued_replies.delete();
            mismatches = 0;
            n_checked  = 0;
            n_refused  = 0;
            n_empty    = 0;
        end
        else
        begin
            // Predict the reply for every accepted command beat
            if (s_axis_tvalid && s_axis_tready)
                queued_replies.push_back(serve_command(s_axis_tuser,
                                                       s_axis_tdata[0 +: VALUE_W],
                                                       s_axis_tdata[VALUE_W +: PRI_W]));

            // Compare every accepted result beat with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value   = m_axis_tdata[0 +: VALUE_W];
                got.pri     = m_axis_tdata[VALUE_W +: PRI_W];
                got.entries = m_axis_tdata[VALUE_W + PRI_W +: ENTRIES_W];
                got.pad     = m_axis_tdata[M_TDATA_W-1 -: PAD_W];
                got.status  = m_axis_tuser;
                if (queued_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat with nothing outstanding: tdata %h tuser %h",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = queued_replies.pop_front();
                    n_checked++;
                    if (got.value !== want.value || got.pri !== want.pri ||
                        got.entries !== want.entries || got.pad !== want.pad ||
                        got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch on result %0d", $realtime, n_checked);
                            $display("    value    exp %0d got %0d",
                                     $signed(want.value), $signed(got.value));
                            $display("    priority exp %0d got %0d", want.pri, got.pri);
                            $display("    status   exp %0d got %0d", want.status, got.status);
                            $display("    entries  exp %0d got %0d", want.entries, got.entries);
                            $display("    padding  exp %0h got %0h", want.pad, got.pad);
                        end
                    end
                end
            end
        end
    end

    // Publish the tallies without racing the stimulus process
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count  <= 0;
            pending     <= 0;
            checked     <= 0;
            refused     <= 0;
            empty_reads <= 0;
        end
        else
        begin
            fail_count  <= mismatches;
            pending     <= queued_replies.size();
            checked     <= n_checked;
            refused     <= n_refused;
            empty_reads <= n_empty;
        end
    end

endmodule

// ----- test/sorted_priority_queue_test.sv -----
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 1950;
    localparam int PHASE_LEN    = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int refused;
    int empty_reads;

    int send_gap_pct   = 20;
    int take_stall_pct = 10;
    int sent_per_cmd [4];
    int idle_cycles    = 0;

    sorted_priority_queue dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_priority_queue_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .refused       (refused),
        .empty_reads   (empty_reads)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Offer one command beat, after an optional idle burst, and hold it until taken
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                             input logic [PRI_W-1:0] pri);
        int gap;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            gap = $urandom_range(17, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pri, value};
        s_axis_tuser  <= cmd;
        sent_per_cmd[cmd]++;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Pick a value, now and then one of the extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(15) == 0)
        begin
            case ($urandom_range(3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    // Stall the result side in random bursts
    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (take_stall_pct > 0 && $urandom_range(99) < take_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Give up when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                 counted;
        int                 phase_end;
        int                 mix;
        int                 pri_mode;
        int                 band_base;
        int                 roll;
        int                 ins_cut;
        int                 deq_cut;
        logic [CMD_W-1:0]   cmd;
        logic [PRI_W-1:0]   pri;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_INSERT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: reads report empty, unused code is ignored
        send_beat(CMD_PEEK, $urandom, PRI_W'($urandom));
        send_beat(CMD_DEQUEUE, $urandom, PRI_W'($urandom));
        send_beat(CMD_UNUSED, $urandom, PRI_W'($urandom));

        // Fill to the brim with extreme values, extreme priorities and ties
        send_beat(CMD_INSERT, 32'h8000_0000, 16'hFFFF);
        send_beat(CMD_INSERT, 32'h7FFF_FFFF, 16'h0000);
        send_beat(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(CMD_INSERT, 32'h0000_0000, 16'h0000);
        for (int i = 0; i < DEPTH - 4; i++)
            send_beat(CMD_INSERT, $urandom, PRI_W'((i / 2) * 9000 + 1));

        // Full queue: insert refused, then the most recent top tie is served
        send_beat(CMD_INSERT, $urandom, PRI_W'($urandom));
        send_beat(CMD_PEEK, $urandom, PRI_W'($urandom));
        send_beat(CMD_DEQUEUE, $urandom, PRI_W'($urandom));
        send_beat(CMD_UNUSED, $urandom, PRI_W'($urandom));

        // Random phases, each with its own command mix, priority spread and idling
        counted = 0;
        while (counted < ITEM_TARGET)
        begin
            mix       = $urandom_range(2);
            pri_mode  = $urandom_range(3);
            band_base = $urandom_range(65535 - 15);
            case (mix)
                0:       begin ins_cut = 65; deq_cut = 85; end   // filling
                1:       begin ins_cut = 25; deq_cut = 75; end   // draining
                default: begin ins_cut = 45; deq_cut = 80; end
            endcase
            if (counted + PHASE_LEN >= ITEM_TARGET)
            begin
                send_gap_pct   = 0;
                take_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(3))
                    0:       send_gap_pct = 0;
                    1:       send_gap_pct = 5;
                    2:       send_gap_pct = 20;
                    default: send_gap_pct = 50;
                endcase
                case ($urandom_range(3))
                    0:       take_stall_pct = 0;
                    1:       take_stall_pct = 3;
                    2:       take_stall_pct = 10;
                    default: take_stall_pct = 30;
                endcase
            end

            phase_end = counted + PHASE_LEN;
            while (counted < phase_end && counted < ITEM_TARGET)
            begin
                roll = $urandom_range(99);
                if (roll < ins_cut)
                    cmd = CMD_INSERT;
                else if (roll < deq_cut)
                    cmd = CMD_DEQUEUE;
                else if (roll < 97)
                    cmd = CMD_PEEK;
                else
                    cmd = CMD_UNUSED;
                case (pri_mode)
                    0: pri = PRI_W'($urandom_range(65535));
                    1: pri = PRI_W'($urandom_range(3));
                    2:
                    begin
                        case ($urandom_range(3))
                            0:       pri = 16'h0000;
                            1:       pri = 16'h0001;
                            2:       pri = 16'hFFFE;
                            default: pri = 16'hFFFF;
                        endcase
                    end
                    default: pri = PRI_W'(band_base + $urandom_range(15));
                endcase
                send_beat(cmd, pick_value(), pri);
                if (cmd != CMD_UNUSED)
                    counted++;
            end
        end

        // Drain: wait for every reply, then watch a little longer for strays
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d inserts, %0d dequeues, %0d peeks and %0d unused-code beats.",
                 sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_DEQUEUE],
                 sent_per_cmd[CMD_PEEK], sent_per_cmd[CMD_UNUSED]);
        $display("Checked %0d replies: %0d refused inserts, %0d reads of an empty queue.",
                 checked, refused, empty_reads);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
